// File: rtl/itda_pkg.sv
// ----------------------------------------------------------------------------
// itda_pkg: shared types and constants for the decimal ASCII converter
// Field widths, the ASCII digit base, cell control and controller states.
// ----------------------------------------------------------------------------
package itda_pkg;

  // Field widths of the input and result items.
  localparam int VALUE_W = 31;
  localparam int LEN_W   = 4;
  localparam int CHAR_W  = 8;
  localparam int COUNT_W = 4;
  localparam int BCD_W   = 4;

  // Packed stream widths, padded to whole bytes.
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;

  // Bit counter width; it counts down over the value bits.
  localparam int BITCNT_W = 5;

  // ASCII code of the character zero.
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'h30;

  // Largest BCD digit that shifts without the add-three correction.
  localparam logic [BCD_W-1:0] BCD_ADJ_LIMIT = 4'd4;
  localparam logic [BCD_W-1:0] BCD_ADJ_ADD   = 4'd3;

  // Control sent from the controller to every digit cell.
  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctrl_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_FIND,
    ST_EMIT
  } itda_state_t;

endpackage

// File: rtl/itda_bcd_cell.sv
// ----------------------------------------------------------------------------
// itda_bcd_cell: one decimal digit of the shift-and-add-three chain
// Holds one BCD digit; on each shift it corrects the digit, shifts in the
// bit from the cell below and hands its top bit to the cell above.
// ----------------------------------------------------------------------------
module itda_bcd_cell
  import itda_pkg::*;
(
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  logic             shift_in,
  output logic             shift_out,
  output logic [BCD_W-1:0] digit
);

  logic [BCD_W-1:0] digit_r;
  logic [BCD_W-1:0] digit_nxt;
  logic [BCD_W-1:0] adjusted;

  // Add three to digits of five or more so the shift stays in decimal.
  always_comb begin
    adjusted  = (digit_r > BCD_ADJ_LIMIT) ? (digit_r + BCD_ADJ_ADD) : digit_r;
    shift_out = adjusted[BCD_W-1];
    digit_nxt = digit_r;
    if (ctrl.clear) begin
      digit_nxt = '0;
    end else if (ctrl.shift) begin
      digit_nxt = {adjusted[BCD_W-2:0], shift_in};
    end
  end

  // Digit register.
  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

  assign digit = digit_r;

endmodule

// File: rtl/int_to_decimal_ascii_unit.sv
// ----------------------------------------------------------------------------
// int_to_decimal_ascii_unit: binary integer to decimal ASCII digit stream
// Flow: after the input transfer the value shifts MSB first through the digit
// chain, a find step locates the lead digit, and then the results are emitted.
// A new item is taken only after the last result of the previous one is registered.
// Results leave at one per cycle while out_tready is high.
// Reset: synchronous active-low rst_n clears the controller and output valid.
// ----------------------------------------------------------------------------
module int_to_decimal_ascii_unit
  import itda_pkg::*;
#(
  parameter int MAX_DIGITS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,  // value[30:0], max_len[34:31], zero pad
  // Result stream.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata, // digit_char[7:0], overflow[8], count[12:9]
  output logic                  out_tlast
);

  localparam int CW   = $clog2(MAX_DIGITS + 1);
  localparam int IW   = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CMPW = (CW > LEN_W) ? CW : LEN_W;

  // Controller state and datapath registers.
  itda_state_t          state_r, state_nxt;
  logic [VALUE_W-1:0]   value_r, value_nxt;
  logic [LEN_W-1:0]     max_len_r, max_len_nxt;
  logic [BITCNT_W-1:0]  bitcnt_r, bitcnt_nxt;
  logic                 carry_r, carry_nxt;
  logic [CW-1:0]        ndig_r, ndig_nxt;
  logic                 special_r, special_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [IW-1:0]        pos_r, pos_nxt;

  // Output register.
  logic                 out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]    out_char_r, out_char_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 out_ovf_r, out_ovf_nxt;
  logic [COUNT_W-1:0]   out_count_r, out_count_nxt;

  cell_ctrl_t           cell_ctrl;
  logic [MAX_DIGITS:0]  carry;
  logic [BCD_W-1:0]     digits [MAX_DIGITS];
  logic [CW-1:0]        ndig_found;
  logic                 out_free;

  // Chain of digit cells; the value enters at the bottom, MSB first.
  assign carry[0] = value_r[VALUE_W-1];

  for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_cell
    itda_bcd_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl),
      .shift_in  (carry[g]),
      .shift_out (carry[g+1]),
      .digit     (digits[g])
    );
  end

  // Number of significant digits: one past the highest nonzero cell.
  always_comb begin
    ndig_found = '0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (digits[i] != '0) begin
        ndig_found = CW'(i + 1);
      end
    end
  end

  assign out_free = !out_valid_r || out_tready;

  // Next state, cell control and result selection.
  always_comb begin
    state_nxt      = state_r;
    value_nxt      = value_r;
    max_len_nxt    = max_len_r;
    bitcnt_nxt     = bitcnt_r;
    carry_nxt      = carry_r;
    ndig_nxt       = ndig_r;
    special_nxt    = special_r;
    ovf_nxt        = ovf_r;
    pos_nxt        = pos_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_char_nxt   = out_char_r;
    out_last_nxt   = out_last_r;
    out_ovf_nxt    = out_ovf_r;
    out_count_nxt  = out_count_r;
    cell_ctrl      = '{clear: 1'b0, shift: 1'b0};
    in_tready      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          value_nxt   = in_tdata[VALUE_W-1:0];
          max_len_nxt = in_tdata[VALUE_W+LEN_W-1:VALUE_W];
          bitcnt_nxt  = BITCNT_W'(VALUE_W - 1);
          carry_nxt   = 1'b0;
          cell_ctrl   = '{clear: 1'b1, shift: 1'b0};
          state_nxt   = ST_CONV;
        end
      end
      ST_CONV: begin
        // One value bit enters the chain per cycle.
        cell_ctrl = '{clear: 1'b0, shift: 1'b1};
        value_nxt = {value_r[VALUE_W-2:0], 1'b0};
        carry_nxt = carry_r || carry[MAX_DIGITS];
        if (bitcnt_r == '0) begin
          state_nxt = ST_FIND;
        end else begin
          bitcnt_nxt = bitcnt_r - 1'b1;
        end
      end
      ST_FIND: begin
        // Too many digits if the chain spilled or the count beats the limit.
        ndig_nxt    = ndig_found;
        ovf_nxt     = carry_r || (CMPW'(ndig_found) > CMPW'(max_len_r));
        special_nxt = ovf_nxt || (ndig_found == '0);
        pos_nxt     = IW'(ndig_found - 1'b1);
        state_nxt   = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (special_r) begin
            out_last_nxt = 1'b1;
            out_ovf_nxt  = ovf_r;
            if (!ovf_r && (max_len_r != '0)) begin
              // Zero with room for one digit prints a single zero.
              out_char_nxt  = ASCII_ZERO;
              out_count_nxt = COUNT_W'(1);
            end else begin
              out_char_nxt  = '0;
              out_count_nxt = '0;
            end
            state_nxt = ST_IDLE;
          end else begin
            out_char_nxt  = ASCII_ZERO + CHAR_W'(digits[pos_r]);
            out_ovf_nxt   = 1'b0;
            out_count_nxt = COUNT_W'(ndig_r);
            out_last_nxt  = (pos_r == '0);
            if (pos_r == '0) begin
              state_nxt = ST_IDLE;
            end else begin
              pos_nxt = pos_r - 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    value_r     <= value_nxt;
    max_len_r   <= max_len_nxt;
    bitcnt_r    <= bitcnt_nxt;
    carry_r     <= carry_nxt;
    ndig_r      <= ndig_nxt;
    special_r   <= special_nxt;
    ovf_r       <= ovf_nxt;
    pos_r       <= pos_nxt;
    out_char_r  <= out_char_nxt;
    out_last_r  <= out_last_nxt;
    out_ovf_r   <= out_ovf_nxt;
    out_count_r <= out_count_nxt;
  end

  // Result stream ports.
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {3'b000, out_count_r, out_ovf_r, out_char_r};

  // An overflow result carries no character and no count.
  a_ovf_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ovf_r) |-> (out_last_r && out_char_r == '0 && out_count_r == '0))
    else $error("overflow result with a character or count");

  // A digit result is always an ASCII digit.
  a_digit_char: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_count_r != '0) |->
      (out_char_r >= ASCII_ZERO && out_char_r <= ASCII_ZERO + CHAR_W'(9)))
    else $error("digit result outside the ASCII digit range");

  // Input is taken only while no conversion or emission is under way.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_tready)
    else $error("input ready while a conversion is in flight");

endmodule
